[hdl/asrc_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// asrc_pkg
// Types, codes and reset values shared by the send/retry controller files.
// ----------------------------------------------------------------------------
package asrc_pkg;

    localparam int ADDR_W  = 5;
    localparam int DATA_W  = 32;
    localparam int TIMER_W = 27;
    localparam int COUNT_W = 5;

    // Request codes of an input transaction
    localparam logic [1:0] REQ_START   = 2'd0;
    localparam logic [1:0] REQ_OUTCOME = 2'd1;
    localparam logic [1:0] REQ_ACK     = 2'd2;
    localparam logic [1:0] REQ_TICK    = 2'd3;

    // Transmitter outcome codes
    localparam logic [1:0] TX_OK        = 2'd0;
    localparam logic [1:0] TX_TRANSIENT = 2'd1;

    // Result status codes
    localparam logic [2:0] ST_NONE    = 3'd0;
    localparam logic [2:0] ST_OK      = 3'd1;
    localparam logic [2:0] ST_TXFAIL  = 3'd2;
    localparam logic [2:0] ST_ACKFAIL = 3'd3;
    localparam logic [2:0] ST_HARD    = 3'd4;

    // Register indexes (byte address is four times the index)
    localparam logic [2:0] REG_ACK_TIMEOUT = 3'd0;
    localparam logic [2:0] REG_TOWER_RELAX = 3'd1;
    localparam logic [2:0] REG_ACK_RELAX   = 3'd2;
    localparam logic [2:0] REG_MAX_TX_FAIL = 3'd3;
    localparam logic [2:0] REG_MAX_ACK_MISS = 3'd4;

    // Register reset values
    localparam logic [15:0] RST_ACK_TIMEOUT  = 16'd200;
    localparam logic [9:0]  RST_TOWER_RELAX  = 10'd100;
    localparam logic [9:0]  RST_ACK_RELAX    = 10'd50;
    localparam logic [3:0]  RST_MAX_TX_FAIL  = 4'd7;
    localparam logic [3:0]  RST_MAX_ACK_MISS = 4'd5;

    typedef enum logic [3:0] {
        PH_IDLE    = 4'b0001,
        PH_TXWAIT  = 4'b0010,
        PH_ACKWAIT = 4'b0100,
        PH_BACKOFF = 4'b1000
    } phase_t;

    typedef struct packed {
        logic [1:0] req_type;
        logic [1:0] tx_outcome;
    } in_t;

    typedef struct packed {
        logic               send_now;
        logic [2:0]         status;
        logic               busy_res;
        logic [COUNT_W-1:0] tx_failures_seen;
        logic [COUNT_W-1:0] ack_misses_seen;
    } out_t;

    typedef struct packed {
        logic [15:0] ack_timeout_ms;
        logic [9:0]  tower_relax_ms;
        logic [9:0]  ack_relax_ms;
        logic [3:0]  max_tx_failures;
        logic [3:0]  max_ack_misses;
    } cfg_t;

    typedef struct packed {
        phase_t             phase;
        logic [COUNT_W-1:0] tx_fail_count;
        logic [COUNT_W-1:0] ack_miss_count;
        logic [TIMER_W-1:0] wait_timer;
        logic               ack_latched;
    } state_t;

endpackage
`default_nettype wire

[hdl/asrc_regs.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// asrc_regs
// APB register file holding the timeout, backoff bases and retry limits.
// ----------------------------------------------------------------------------
module asrc_regs (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [asrc_pkg::ADDR_W-1:0]   paddr,
    input  wire logic [asrc_pkg::DATA_W-1:0]   pwdata,
    output logic      [asrc_pkg::DATA_W-1:0]   prdata,
    output logic                               pready,
    output asrc_pkg::cfg_t                     cfg
);

    asrc_pkg::cfg_t cfg_reg;
    asrc_pkg::cfg_t cfg_next;
    logic [2:0]     index;
    logic           wr_en;

    assign index  = paddr[asrc_pkg::ADDR_W-1:2];
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            unique case (index)
                asrc_pkg::REG_ACK_TIMEOUT:  cfg_next.ack_timeout_ms  = pwdata[15:0];
                asrc_pkg::REG_TOWER_RELAX:  cfg_next.tower_relax_ms  = pwdata[9:0];
                asrc_pkg::REG_ACK_RELAX:    cfg_next.ack_relax_ms    = pwdata[9:0];
                asrc_pkg::REG_MAX_TX_FAIL:  cfg_next.max_tx_failures = pwdata[3:0];
                asrc_pkg::REG_MAX_ACK_MISS: cfg_next.max_ack_misses  = pwdata[3:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (index)
            asrc_pkg::REG_ACK_TIMEOUT:  prdata = {16'd0, cfg_reg.ack_timeout_ms};
            asrc_pkg::REG_TOWER_RELAX:  prdata = {22'd0, cfg_reg.tower_relax_ms};
            asrc_pkg::REG_ACK_RELAX:    prdata = {22'd0, cfg_reg.ack_relax_ms};
            asrc_pkg::REG_MAX_TX_FAIL:  prdata = {28'd0, cfg_reg.max_tx_failures};
            asrc_pkg::REG_MAX_ACK_MISS: prdata = {28'd0, cfg_reg.max_ack_misses};
            default:                    prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.ack_timeout_ms  <= asrc_pkg::RST_ACK_TIMEOUT;
            cfg_reg.tower_relax_ms  <= asrc_pkg::RST_TOWER_RELAX;
            cfg_reg.ack_relax_ms    <= asrc_pkg::RST_ACK_RELAX;
            cfg_reg.max_tx_failures <= asrc_pkg::RST_MAX_TX_FAIL;
            cfg_reg.max_ack_misses  <= asrc_pkg::RST_MAX_ACK_MISS;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule
`default_nettype wire

[hdl/asrc_core.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// asrc_core
// Next-state and result logic for one event of the stop-and-wait sender.
// ----------------------------------------------------------------------------
module asrc_core (
    input  wire asrc_pkg::state_t state,
    input  wire asrc_pkg::cfg_t   cfg,
    input  wire asrc_pkg::in_t    item,
    output asrc_pkg::state_t      state_next,
    output asrc_pkg::out_t        result
);

    localparam int TW = asrc_pkg::TIMER_W;
    localparam int CW = asrc_pkg::COUNT_W;

    logic [CW-1:0] tx_inc;
    logic [CW-1:0] ack_inc;
    logic [TW-1:0] tx_backoff;
    logic [TW-1:0] ack_backoff;
    logic          expired;
    logic [TW-1:0] timer_dec;
    logic          send;
    logic [2:0]    status;

    assign tx_inc  = state.tx_fail_count + CW'(1);
    assign ack_inc = state.ack_miss_count + CW'(1);
    // Backoff is the base shifted by the incremented count, cut to the timer width.
    assign tx_backoff  = TW'(cfg.tower_relax_ms) << tx_inc;
    assign ack_backoff = TW'(cfg.ack_relax_ms) << ack_inc;
    // A tick with the timer at zero or one ends the wait.
    assign expired   = (state.wait_timer <= TW'(1));
    assign timer_dec = state.wait_timer - TW'(1);

    always_comb begin
        state_next = state;
        send       = 1'b0;
        status     = asrc_pkg::ST_NONE;
        unique case (item.req_type)
            asrc_pkg::REQ_START: begin
                if (state.phase == asrc_pkg::PH_IDLE) begin
                    state_next.tx_fail_count  = '0;
                    state_next.ack_miss_count = '0;
                    state_next.wait_timer     = '0;
                    state_next.ack_latched    = 1'b0;
                    state_next.phase          = asrc_pkg::PH_TXWAIT;
                    send                      = 1'b1;
                end
            end
            asrc_pkg::REQ_OUTCOME: begin
                if (state.phase == asrc_pkg::PH_TXWAIT) begin
                    state_next.ack_latched = 1'b0;
                    if (item.tx_outcome == asrc_pkg::TX_OK) begin
                        if (state.ack_latched) begin
                            state_next.phase = asrc_pkg::PH_IDLE;
                            status           = asrc_pkg::ST_OK;
                        end else begin
                            state_next.wait_timer = TW'(cfg.ack_timeout_ms);
                            state_next.phase      = asrc_pkg::PH_ACKWAIT;
                        end
                    end else if (item.tx_outcome == asrc_pkg::TX_TRANSIENT) begin
                        state_next.tx_fail_count = tx_inc;
                        if (tx_inc > CW'(cfg.max_tx_failures)) begin
                            state_next.phase      = asrc_pkg::PH_IDLE;
                            state_next.wait_timer = '0;
                            status                = asrc_pkg::ST_TXFAIL;
                        end else begin
                            state_next.wait_timer = tx_backoff;
                            state_next.phase      = asrc_pkg::PH_BACKOFF;
                        end
                    end else begin
                        // Any other outcome code counts as a hard error.
                        state_next.phase      = asrc_pkg::PH_IDLE;
                        state_next.wait_timer = '0;
                        status                = asrc_pkg::ST_HARD;
                    end
                end
            end
            asrc_pkg::REQ_ACK: begin
                if (state.phase == asrc_pkg::PH_TXWAIT) begin
                    state_next.ack_latched = 1'b1;
                end else if (state.phase == asrc_pkg::PH_ACKWAIT) begin
                    state_next.phase      = asrc_pkg::PH_IDLE;
                    state_next.wait_timer = '0;
                    status                = asrc_pkg::ST_OK;
                end
            end
            asrc_pkg::REQ_TICK: begin
                if (state.phase == asrc_pkg::PH_ACKWAIT ||
                    state.phase == asrc_pkg::PH_BACKOFF) begin
                    state_next.wait_timer = expired ? '0 : timer_dec;
                end
                if (expired && state.phase == asrc_pkg::PH_ACKWAIT) begin
                    state_next.ack_miss_count = ack_inc;
                    if (ack_inc > CW'(cfg.max_ack_misses)) begin
                        state_next.phase = asrc_pkg::PH_IDLE;
                        status           = asrc_pkg::ST_ACKFAIL;
                    end else begin
                        state_next.wait_timer = ack_backoff;
                        state_next.phase      = asrc_pkg::PH_BACKOFF;
                    end
                end else if (expired && state.phase == asrc_pkg::PH_BACKOFF) begin
                    state_next.ack_latched = 1'b0;
                    state_next.phase       = asrc_pkg::PH_TXWAIT;
                    send                   = 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_comb begin
        result.send_now         = send;
        result.status           = status;
        result.busy_res         = (state_next.phase != asrc_pkg::PH_IDLE);
        result.tx_failures_seen = state_next.tx_fail_count;
        result.ack_misses_seen  = state_next.ack_miss_count;
    end

endmodule
`default_nettype wire

[hdl/assured_send_retry_controller_unit.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// assured_send_retry_controller_unit
// Stop-and-wait sender controller with exponential backoff on failures.
// ----------------------------------------------------------------------------
// Every input transaction (start, transmitter outcome, acknowledge or a
// millisecond tick) produces exactly one result transaction in the cycle after
// it is accepted, and a new transaction can be accepted in every cycle: the
// whole update is one pass of logic from the state registers into the result
// register, and s_ready stays high whenever that result register is empty or
// being taken in the same cycle. Registers at byte addresses 0x00 ack
// timeout, 0x04 transmitter backoff base, 0x08 acknowledge backoff base,
// 0x0C transmitter failure limit and 0x10 acknowledge miss limit; write them
// only while the controller is idle.
// ----------------------------------------------------------------------------
module assured_send_retry_controller_unit (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        s_valid,
    output logic                             s_ready,
    input  wire asrc_pkg::in_t               s_data,
    output logic                             m_valid,
    input  wire logic                        m_ready,
    output asrc_pkg::out_t                   m_data,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [asrc_pkg::ADDR_W-1:0] paddr,
    input  wire logic [asrc_pkg::DATA_W-1:0] pwdata,
    output logic      [asrc_pkg::DATA_W-1:0] prdata,
    output logic                             pready
);

    asrc_pkg::cfg_t   cfg;
    asrc_pkg::state_t state_reg;
    asrc_pkg::state_t state_next;
    asrc_pkg::out_t   result;
    asrc_pkg::out_t   out_reg;
    logic             m_valid_reg;
    logic             m_valid_next;
    logic             accept;

    asrc_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    asrc_core u_core (
        .state      (state_reg),
        .cfg        (cfg),
        .item       (s_data),
        .state_next (state_next),
        .result     (result)
    );

    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;
    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

    always_comb begin
        m_valid_next = m_valid_reg;
        if (accept) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg.phase          <= asrc_pkg::PH_IDLE;
            state_reg.tx_fail_count  <= '0;
            state_reg.ack_miss_count <= '0;
            state_reg.wait_timer     <= '0;
            state_reg.ack_latched    <= 1'b0;
            m_valid_reg              <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
            if (accept) begin
                state_reg <= state_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            out_reg <= result;
        end
    end

    // The busy flag of a fresh result must match the state it left behind.
    a_busy_matches: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> m_valid && (m_data.busy_res == (state_reg.phase != asrc_pkg::PH_IDLE)))
        else $error("busy_res disagrees with the stored phase");

    // A finishing status always ends the exchange.
    a_status_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> (m_data.status == asrc_pkg::ST_NONE) || !m_data.busy_res)
        else $error("exchange still busy after a final status");

    // A send request leaves the controller waiting for the transmitter.
    a_send_txwait: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> !m_data.send_now || (state_reg.phase == asrc_pkg::PH_TXWAIT))
        else $error("send_now without entering the transmitter wait");

    // The timer only runs while waiting for an acknowledge or backing off.
    a_timer_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg.phase == asrc_pkg::PH_IDLE || state_reg.phase == asrc_pkg::PH_TXWAIT)
        |-> (state_reg.wait_timer == '0))
        else $error("wait timer running outside a timed phase");

    // A result waiting at a stalled output must not be overwritten.
    a_no_overrun: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |-> !accept)
        else $error("new transaction accepted over a pending result");

endmodule
`default_nettype wire

[tb/assured_send_retry_controller_unit_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// assured_send_retry_controller_unit_tb
// Self-checking testbench for the stop-and-wait send/retry controller.
// ----------------------------------------------------------------------------
// A scoreboard class keeps its own copy of the controller state and of the
// registers. It works out the status report that each accepted event should
// produce, and compares the reports that arrive, field by field. A short
// directed run covers ignored events, the acknowledge latch, both timeouts
// and the extreme register settings. Randomised exchanges then follow under
// several register settings. Both handshakes stall at random throughout.
// ----------------------------------------------------------------------------
module assured_send_retry_controller_unit_tb;
    import asrc_pkg::*;

    // Outcome codes with no name in the package; both end the exchange.
    localparam logic [1:0] TX_HARD     = 2'd2;
    localparam logic [1:0] TX_RESERVED = 2'd3;

    localparam int MAX_WAIT     = 18;
    localparam int PHASE_EVENTS = 180;
    localparam int WATCHDOG_NS  = 10_000_000;

    class retry_scoreboard;
        cfg_t               regs;
        phase_t             stage;
        logic [COUNT_W-1:0] fails;
        logic [COUNT_W-1:0] misses;
        logic [TIMER_W-1:0] timer;
        logic               ack_held;
        out_t               reports_due[$];
        int                 error_count;
        int                 report_no;

        function new();
            regs.ack_timeout_ms  = RST_ACK_TIMEOUT;
            regs.tower_relax_ms  = RST_TOWER_RELAX;
            regs.ack_relax_ms    = RST_ACK_RELAX;
            regs.max_tx_failures = RST_MAX_TX_FAIL;
            regs.max_ack_misses  = RST_MAX_ACK_MISS;
            stage       = PH_IDLE;
            fails       = '0;
            misses      = '0;
            timer       = '0;
            ack_held    = 1'b0;
            error_count = 0;
            report_no   = 0;
        endfunction

        task flag(string msg);
            $display("ERROR at %0t ns: %s", $time, msg);
            error_count++;
        endtask

        function void set_reg(logic [2:0] idx, logic [31:0] value);
            case (idx)
                REG_ACK_TIMEOUT:  regs.ack_timeout_ms  = value[15:0];
                REG_TOWER_RELAX:  regs.tower_relax_ms  = value[9:0];
                REG_ACK_RELAX:    regs.ack_relax_ms    = value[9:0];
                REG_MAX_TX_FAIL:  regs.max_tx_failures = value[3:0];
                REG_MAX_ACK_MISS: regs.max_ack_misses  = value[3:0];
                default: ;
            endcase
        endfunction

        function logic [31:0] reg_value(logic [2:0] idx);
            case (idx)
                REG_ACK_TIMEOUT:  return 32'(regs.ack_timeout_ms);
                REG_TOWER_RELAX:  return 32'(regs.tower_relax_ms);
                REG_ACK_RELAX:    return 32'(regs.ack_relax_ms);
                REG_MAX_TX_FAIL:  return 32'(regs.max_tx_failures);
                REG_MAX_ACK_MISS: return 32'(regs.max_ack_misses);
                default:          return '0;
            endcase
        endfunction

        function logic [TIMER_W-1:0] backoff(logic [9:0] base, logic [COUNT_W-1:0] n);
            return TIMER_W'(base) << n;
        endfunction

        // A tick with one millisecond or less left ends the wait, so a zero
        // timeout or backoff runs out on the very next tick.
        function bit tick_expires();
            if (timer <= 1) begin
                timer = '0;
                return 1'b1;
            end
            timer = timer - 1'b1;
            return 1'b0;
        endfunction

        function void note_event(in_t ev);
            out_t rep;
            rep = '0;
            case (ev.req_type)
                REQ_START: begin
                    if (stage == PH_IDLE) begin
                        fails        = '0;
                        misses       = '0;
                        timer        = '0;
                        ack_held     = 1'b0;
                        stage        = PH_TXWAIT;
                        rep.send_now = 1'b1;
                    end
                end
                REQ_OUTCOME: begin
                    if (stage == PH_TXWAIT) begin
                        if (ev.tx_outcome == TX_OK) begin
                            // An acknowledge that overtook the outcome completes
                            // the exchange at once.
                            if (ack_held) begin
                                ack_held   = 1'b0;
                                stage      = PH_IDLE;
                                rep.status = ST_OK;
                            end else begin
                                timer = TIMER_W'(regs.ack_timeout_ms);
                                stage = PH_ACKWAIT;
                            end
                        end else if (ev.tx_outcome == TX_TRANSIENT) begin
                            ack_held = 1'b0;
                            fails    = fails + 1'b1;
                            if (fails > regs.max_tx_failures) begin
                                stage      = PH_IDLE;
                                timer      = '0;
                                rep.status = ST_TXFAIL;
                            end else begin
                                timer = backoff(regs.tower_relax_ms, fails);
                                stage = PH_BACKOFF;
                            end
                        end else begin
                            ack_held   = 1'b0;
                            stage      = PH_IDLE;
                            timer      = '0;
                            rep.status = ST_HARD;
                        end
                    end
                end
                REQ_ACK: begin
                    if (stage == PH_TXWAIT) begin
                        ack_held = 1'b1;
                    end else if (stage == PH_ACKWAIT) begin
                        stage      = PH_IDLE;
                        timer      = '0;
                        rep.status = ST_OK;
                    end
                end
                default: begin
                    if (stage == PH_ACKWAIT) begin
                        if (tick_expires()) begin
                            misses = misses + 1'b1;
                            if (misses > regs.max_ack_misses) begin
                                stage      = PH_IDLE;
                                rep.status = ST_ACKFAIL;
                            end else begin
                                timer = backoff(regs.ack_relax_ms, misses);
                                stage = PH_BACKOFF;
                            end
                        end
                    end else if (stage == PH_BACKOFF) begin
                        if (tick_expires()) begin
                            ack_held     = 1'b0;
                            stage        = PH_TXWAIT;
                            rep.send_now = 1'b1;
                        end
                    end
                end
            endcase
            rep.busy_res         = (stage != PH_IDLE);
            rep.tx_failures_seen = fails;
            rep.ack_misses_seen  = misses;
            reports_due.push_back(rep);
        endfunction

        task check_field(string name, int n, logic [7:0] got, logic [7:0] want);
            if (got !== want) begin
                flag($sformatf("report %0d: %s is %0d, expected %0d", n, name, got, want));
            end
        endtask

        task check_report(out_t got);
            out_t want;
            report_no++;
            if (reports_due.size() == 0) begin
                flag($sformatf("report %0d arrived with nothing outstanding", report_no));
                return;
            end
            want = reports_due.pop_front();
            check_field("send_now", report_no, got.send_now, want.send_now);
            check_field("status", report_no, got.status, want.status);
            check_field("busy_res", report_no, got.busy_res, want.busy_res);
            check_field("tx_failures_seen", report_no, got.tx_failures_seen,
                        want.tx_failures_seen);
            check_field("ack_misses_seen", report_no, got.ack_misses_seen,
                        want.ack_misses_seen);
        endtask
    endclass

    logic              aclk;
    logic              aresetn;
    logic              s_valid;
    logic              s_ready;
    in_t               s_data;
    logic              m_valid;
    logic              m_ready;
    out_t              m_data;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    retry_scoreboard sb = new();
    int s_calm = 0;
    int m_calm = 0;

    assured_send_retry_controller_unit DUT (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #(WATCHDOG_NS);
        $display("Timeout: the run did not come to its end");
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Now and then a side runs for a stretch with no stalls at all.
    function automatic int pick_wait(inout int calm);
        if (calm > 0) begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 39) == 0) begin
            calm = $urandom_range(8, 40);
        end
        return $urandom_range(0, MAX_WAIT);
    endfunction

    function automatic cfg_t make_cfg(logic [15:0] tmo, logic [9:0] tower, logic [9:0] ackr,
                                      logic [3:0] max_tx, logic [3:0] max_ack);
        cfg_t c;
        c.ack_timeout_ms  = tmo;
        c.tower_relax_ms  = tower;
        c.ack_relax_ms    = ackr;
        c.max_tx_failures = max_tx;
        c.max_ack_misses  = max_ack;
        return c;
    endfunction

    // Each access ends with psel and penable low before the next one may start.
    task automatic apb_xfer(input logic wr, input logic [2:0] idx, input logic [31:0] wdata,
                            output logic [31:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= ADDR_W'({idx, 2'b00});
        pwdata  <= wdata;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (pready !== 1'b1);
        rdata = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic check_reg(input logic [2:0] idx);
        logic [31:0] rd;
        apb_xfer(1'b0, idx, '0, rd);
        if (rd !== sb.reg_value(idx)) begin
            sb.flag($sformatf("register %0d reads 0x%0h, expected 0x%0h",
                              idx, rd, sb.reg_value(idx)));
        end
    endtask

    task automatic check_all_regs();
        check_reg(REG_ACK_TIMEOUT);
        check_reg(REG_TOWER_RELAX);
        check_reg(REG_ACK_RELAX);
        check_reg(REG_MAX_TX_FAIL);
        check_reg(REG_MAX_ACK_MISS);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
        logic [31:0] rd;
        apb_xfer(1'b1, idx, value, rd);
        sb.set_reg(idx, value);
    endtask

    task automatic load_config(input cfg_t c);
        write_reg(REG_ACK_TIMEOUT, 32'(c.ack_timeout_ms));
        write_reg(REG_TOWER_RELAX, 32'(c.tower_relax_ms));
        write_reg(REG_ACK_RELAX, 32'(c.ack_relax_ms));
        write_reg(REG_MAX_TX_FAIL, 32'(c.max_tx_failures));
        write_reg(REG_MAX_ACK_MISS, 32'(c.max_ack_misses));
        check_all_regs();
    endtask

    // Valid is lowered only after an idle draw, so that a transaction sent
    // back to back keeps valid high without a second assignment in the step.
    task automatic send_event(input logic [1:0] req, input logic [1:0] oc);
        in_t ev;
        int  gap;
        ev.req_type   = req;
        ev.tx_outcome = oc;
        gap = pick_wait(s_calm);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= ev;
        do @(posedge aclk); while (s_ready !== 1'b1);
        sb.note_event(ev);
    endtask

    task automatic tick_out_backoff();
        while (sb.stage == PH_BACKOFF) begin
            send_event(REQ_TICK, TX_OK);
        end
    endtask

    // Brings the controller back to idle by the shortest route and waits for
    // every outstanding report, so that the registers can be rewritten.
    task automatic settle();
        while (sb.stage != PH_IDLE) begin
            case (sb.stage)
                PH_TXWAIT:  send_event(REQ_OUTCOME, TX_HARD);
                PH_ACKWAIT: send_event(REQ_ACK, TX_OK);
                default:    send_event(REQ_TICK, TX_OK);
            endcase
        end
        s_valid <= 1'b0;
        while (sb.reports_due.size() != 0) @(posedge aclk);
        repeat (2) @(posedge aclk);
    endtask

    // Mostly well-formed exchanges steered by the predicted phase, with a
    // share of arbitrary events mixed in.
    task automatic random_event(input int fail_pct, input int ack_pct);
        logic [1:0] req;
        logic [1:0] oc;
        int         roll;
        oc   = 2'($urandom_range(0, 3));
        roll = $urandom_range(0, 99);
        if (roll < 8) begin
            req = 2'($urandom_range(0, 3));
        end else begin
            case (sb.stage)
                PH_IDLE: req = REQ_START;
                PH_TXWAIT: begin
                    if (roll < 18) begin
                        req = REQ_ACK;
                    end else begin
                        req  = REQ_OUTCOME;
                        roll = $urandom_range(0, 99);
                        oc   = (roll < fail_pct) ? TX_TRANSIENT :
                               (roll < 94)       ? TX_OK :
                               (roll < 97)       ? TX_HARD : TX_RESERVED;
                    end
                end
                PH_ACKWAIT: req = ($urandom_range(0, 99) < ack_pct) ? REQ_ACK : REQ_TICK;
                default:    req = REQ_TICK;
            endcase
        end
        send_event(req, oc);
    endtask

    task automatic run_phase(input cfg_t c, input int fail_pct, input int ack_pct);
        settle();
        load_config(c);
        repeat (PHASE_EVENTS) random_event(fail_pct, ack_pct);
    endtask

    initial begin : result_sink
        int stall;
        m_ready <= 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            stall = pick_wait(m_calm);
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (m_valid !== 1'b1);
            sb.check_report(m_data);
        end
    end

    initial begin : stimulus
        int guard;
        aresetn <= 1'b0;
        s_valid <= 1'b0;
        s_data  <= '0;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= '0;
        pwdata  <= '0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        check_all_regs();

        // Reset settings: events that must be ignored, a plain exchange and
        // a retry after a transmitter failure, ended by the reserved code.
        send_event(REQ_OUTCOME, TX_OK);
        send_event(REQ_ACK, TX_OK);
        send_event(REQ_TICK, TX_OK);
        send_event(REQ_START, TX_OK);
        send_event(REQ_START, TX_OK);
        send_event(REQ_TICK, TX_RESERVED);
        send_event(REQ_OUTCOME, TX_OK);
        send_event(REQ_ACK, TX_OK);
        send_event(REQ_START, TX_OK);
        send_event(REQ_OUTCOME, TX_TRANSIENT);
        send_event(REQ_ACK, TX_OK);
        tick_out_backoff();
        send_event(REQ_OUTCOME, TX_RESERVED);

        // All registers at zero: the first failure of either kind is fatal.
        settle();
        load_config(make_cfg(16'd0, 10'd0, 10'd0, 4'd0, 4'd0));
        send_event(REQ_START, TX_OK);
        send_event(REQ_OUTCOME, TX_TRANSIENT);
        send_event(REQ_START, TX_OK);
        send_event(REQ_OUTCOME, TX_OK);
        send_event(REQ_TICK, TX_OK);

        settle();
        load_config(make_cfg(16'hFFFF, 10'h3FF, 10'h3FF, 4'hF, 4'hF));
        send_event(REQ_START, TX_OK);
        send_event(REQ_OUTCOME, TX_OK);
        send_event(REQ_ACK, TX_OK);

        // Short backoff bases with the largest limits. The acknowledge latched
        // before a transient failure must be dropped; the one latched later
        // completes.
        settle();
        load_config(make_cfg(16'd0, 10'd3, 10'd2, 4'hF, 4'hF));
        send_event(REQ_START, TX_OK);
        send_event(REQ_ACK, TX_OK);
        send_event(REQ_OUTCOME, TX_TRANSIENT);
        tick_out_backoff();
        send_event(REQ_OUTCOME, TX_OK);
        send_event(REQ_TICK, TX_OK);
        tick_out_backoff();
        send_event(REQ_ACK, TX_OK);
        send_event(REQ_OUTCOME, TX_OK);

        run_phase(make_cfg(16'd3, 10'd1, 10'd1, 4'd3, 4'd2), 30, 30);
        run_phase(make_cfg(16'd0, 10'd0, 10'd0, 4'hF, 4'hF), 70, 10);
        run_phase(make_cfg(16'($urandom_range(0, 12)), 10'($urandom_range(0, 5)),
                           10'($urandom_range(0, 5)), 4'($urandom_range(0, 4)),
                           4'($urandom_range(0, 4))), 35, 25);
        run_phase(make_cfg(16'hFFFF, 10'd2, 10'd3, 4'd2, 4'd1), 40, 20);
        run_phase(make_cfg(16'd1, 10'd3, 10'd2, 4'd5, 4'd4), 25, 15);

        s_valid <= 1'b0;
        guard = 0;
        while (sb.reports_due.size() != 0 && guard < 10000) begin
            @(posedge aclk);
            guard++;
        end
        repeat (10) @(posedge aclk);
        if (sb.reports_due.size() != 0) begin
            sb.flag($sformatf("%0d expected reports never arrived", sb.reports_due.size()));
        end
        if (sb.error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
